// ----- src/multiwave_oscillator_pan_unit_macros.svh -----
// assertion macros for the multiwave oscillator with pan
// used by the top level only, no other dependencies
`ifndef MULTIWAVE_OSCILLATOR_PAN_UNIT_MACROS_SVH
`define MULTIWAVE_OSCILLATOR_PAN_UNIT_MACROS_SVH

// same-cycle implication
`define MWOP_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MWOP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mwop_pkg.sv -----
// shared types, constants and helpers for the multiwave oscillator with pan
// no dependencies; used by every module of the block
package mwop_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS         = 16;
    localparam int STEP_W              = 32;
    localparam int GAIN_W              = 9;
    localparam int WSEL_W              = 3;
    localparam int LFSR_W              = 16;
    localparam int CALC_W              = SAMPLE_BITS + 3;
    localparam int SA_W                = SAMPLE_BITS + 8;
    localparam int MUL_W               = 33;
    localparam int PROD_W              = 2 * MUL_W;
    localparam int SIN_Q               = 30;
    localparam int U_W                 = SIN_Q + 1;
    localparam int FS                  = 2 ** (SAMPLE_BITS - 1);

    localparam logic [U_W-1:0]    SIN_A = 31'd1686629713;
    localparam logic [U_W-1:0]    SIN_B = 31'd688904870;
    localparam logic [U_W-1:0]    SIN_C = 31'd76017005;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hFFFF;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [STEP_W-1:0] STEP_RST  = 32'd42852281;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = 9'd256;
    localparam logic [GAIN_W-1:0] GAIN_RST  = 9'd128;

    localparam logic [WSEL_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WSEL_W-1:0] WAVE_SAWTOOTH = 3'd1;
    localparam logic [WSEL_W-1:0] WAVE_SQUARE   = 3'd2;
    localparam logic [WSEL_W-1:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [WSEL_W-1:0] WAVE_NOISE    = 3'd4;

    typedef enum logic [1:0] {
        REG_PHASE_STEP   = 2'd0,
        REG_WAVE_SELECT  = 2'd1,
        REG_AMPLITUDE    = 2'd2,
        REG_PAN_POSITION = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WAVE,
        ST_SIN_SQ,
        ST_SIN_C,
        ST_SIN_B,
        ST_SIN_A,
        ST_AMP,
        ST_PAN_L,
        ST_PAN_R,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MOP_U_U,
        MOP_C_U2,
        MOP_B_U2,
        MOP_A_U,
        MOP_SAMPLE_AMP,
        MOP_SA_PAN,
        MOP_SA_RPAN
    } mul_op_t;

    typedef struct packed {
        logic in_valid;
        logic tick;
        logic is_sine;
        logic out_free;
    } stat_t;

    typedef struct packed {
        state_t  state;
        logic    in_ready;
        logic    mul_en;
        mul_op_t mul_op;
        logic    load_wave;
        logic    load_u2;
        logic    load_sine;
        logic    load_sa;
        logic    load_left;
        logic    load_out;
    } ctrl_t;

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(
        input logic signed [CALC_W-1:0] v
    );
        logic signed [CALC_W-1:0] hi;
        logic signed [CALC_W-1:0] lo;
        hi = CALC_W'(FS - 1);
        lo = CALC_W'(-FS);
        if (v > hi)
        begin
            clamp_sample = SAMPLE_BITS'(hi);
        end
        else if (v < lo)
        begin
            clamp_sample = SAMPLE_BITS'(lo);
        end
        else
        begin
            clamp_sample = SAMPLE_BITS'(v);
        end
    endfunction

endpackage

// ----- src/mwop_mul.sv -----
// shared multiplier with registered product
// depends on mwop_pkg
module mwop_mul import mwop_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] product
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign product = prod_reg;

endmodule

// ----- src/mwop_wave.sv -----
// sawtooth, square, triangle and noise shapes plus the lfsr step
// depends on mwop_pkg (clamp_sample, wave codes)
module mwop_wave import mwop_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic [PHASE_BITS-1:0]         phase,
    input  logic [WSEL_W-1:0]             wave_select,
    input  logic [LFSR_W-1:0]             lfsr,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic [LFSR_W-1:0]             lfsr_next
);

    logic [PHASE_BITS+15:0]     ext;
    logic [SAMPLE_BITS-1:0]     top_s;
    logic [SAMPLE_BITS:0]       top_t;
    logic signed [CALC_W-1:0]   fs_c;
    logic signed [CALC_W-1:0]   saw_c;
    logic signed [CALC_W-1:0]   tri_c;
    logic                       first_half;

    assign ext        = {phase, 16'b0};
    assign top_s      = ext[PHASE_BITS+15 -: SAMPLE_BITS];
    assign top_t      = ext[PHASE_BITS+15 -: SAMPLE_BITS+1];
    assign first_half = ~phase[PHASE_BITS-1];
    assign fs_c       = CALC_W'(FS);

    assign saw_c = fs_c - $signed(CALC_W'(top_s));
    assign tri_c = first_half ? (fs_c - $signed(CALC_W'(top_t)))
                              : ($signed(CALC_W'(top_t)) - CALC_W'(3 * FS));

    // galois step, one per noise item
    assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);

    always_comb
    begin
        unique case (wave_select)
            WAVE_SAWTOOTH: sample = clamp_sample(saw_c);
            WAVE_SQUARE:   sample = first_half ? SAMPLE_BITS'(-FS) : SAMPLE_BITS'(FS - 1);
            WAVE_TRIANGLE: sample = clamp_sample(tri_c);
            WAVE_NOISE:    sample = $signed(lfsr_next[LFSR_W-1 -: SAMPLE_BITS]);
            default:       sample = '0;
        endcase
    end

endmodule

// ----- src/mwop_ctrl.sv -----
// sequencer that steps the shared multiplier through sine and gain work
// depends on mwop_pkg (state_t, ctrl_t, stat_t)
module mwop_ctrl import mwop_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_valid && stat.tick)
                begin
                    state_next = ST_WAVE;
                end
            end
            ST_WAVE:   state_next = stat.is_sine ? ST_SIN_SQ : ST_AMP;
            ST_SIN_SQ: state_next = ST_SIN_C;
            ST_SIN_C:  state_next = ST_SIN_B;
            ST_SIN_B:  state_next = ST_SIN_A;
            ST_SIN_A:  state_next = ST_AMP;
            ST_AMP:    state_next = ST_PAN_L;
            ST_PAN_L:  state_next = ST_PAN_R;
            ST_PAN_R:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl           = '0;
        ctrl.state     = state_reg;
        ctrl.mul_op    = MOP_U_U;
        unique case (state_reg)
            ST_IDLE:   ctrl.in_ready = 1'b1;
            ST_WAVE:
            begin
                ctrl.load_wave = 1'b1;
                ctrl.mul_en    = 1'b1;
                ctrl.mul_op    = MOP_U_U;
            end
            ST_SIN_SQ:
            begin
                ctrl.load_u2 = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_op  = MOP_C_U2;
            end
            ST_SIN_C:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MOP_B_U2;
            end
            ST_SIN_B:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MOP_A_U;
            end
            ST_SIN_A:  ctrl.load_sine = 1'b1;
            ST_AMP:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MOP_SAMPLE_AMP;
            end
            ST_PAN_L:
            begin
                ctrl.load_sa = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_op  = MOP_SA_PAN;
            end
            ST_PAN_R:
            begin
                ctrl.load_left = 1'b1;
                ctrl.mul_en    = 1'b1;
                ctrl.mul_op    = MOP_SA_RPAN;
            end
            ST_DONE:   ctrl.load_out = stat.out_free;
            default:   ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

// ----- src/multiwave_oscillator_pan_unit.sv -----
// top level of the multiwave oscillator with pan: registers, operand mux, output stage
// depends on mwop_pkg, mwop_mul, mwop_wave, mwop_ctrl and the macros header
//
// usage:
//   s_* channel: one item per sample period; tdata bit 0 is tick. an item with
//   tick low is taken and gives no result. an item with tick high advances the
//   phase by phase_step and yields one stereo item on the m_* channel.
//   cfg_* port: write cfg_data to register cfg_index (0 phase_step,
//   1 wave_select, 2 amplitude, 3 pan_position) while the block is idle.
// sequencing:
//   one shared 33x33 multiplier does all products, one per cycle. sine adds
//   four sequencing steps to the other shapes; the next item is taken only once
//   the previous result has moved into the output register.
// reset:
//   phase 0, lfsr all ones, registers at their defaults, no item pending.
// stall:
//   a finished item waits in the output register; the next item is taken and
//   worked on, and holds in its last step until the output register frees.
`include "multiwave_oscillator_pan_unit_macros.svh"

module multiwave_oscillator_pan_unit import mwop_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [0] tick, [7:1] zero
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,    // [15:0] left_sample, [31:16] right_sample
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [STEP_W-1:0] cfg_data
);

    logic [STEP_W-1:0]     phase_step_reg;
    logic [WSEL_W-1:0]     wave_sel_reg;
    logic [GAIN_W-1:0]     amp_reg;
    logic [GAIN_W-1:0]     pan_reg;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] step_ext;
    logic [LFSR_W-1:0]     lfsr_reg;
    logic [LFSR_W-1:0]     lfsr_next;

    logic [U_W-1:0]                u2_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SA_W-1:0]        sa_reg;
    logic [SAMPLE_BITS-1:0]        left_reg;
    logic [31:0]                   out_data_reg;
    logic                          out_valid_reg;

    logic signed [SAMPLE_BITS-1:0] wave_sample;
    logic signed [SAMPLE_BITS-1:0] sine_mag;
    logic signed [SAMPLE_BITS-1:0] sine_val;

    logic [1:0]                    quad;
    logic [SINE_TABLE_BITS-1:0]    sin_idx;
    logic [SINE_TABLE_BITS:0]      sin_mir;
    logic [U_W-1:0]                sin_u;
    logic [U_W-1:0]                p_q30;
    logic signed [SA_W-1:0]        sa_now;

    logic [GAIN_W-1:0]             amp_sat;
    logic [GAIN_W-1:0]             pan_sat;
    logic [GAIN_W-1:0]             rpan;

    logic signed [MUL_W-1:0]       op_a;
    logic signed [MUL_W-1:0]       op_b;
    logic signed [PROD_W-1:0]      product;

    logic                          accept;
    stat_t                         stat;
    ctrl_t                         ctrl;

    localparam logic [SINE_TABLE_BITS:0] TBL_SIZE = {1'b1, {SINE_TABLE_BITS{1'b0}}};

    assign accept   = s_tvalid && s_tready;
    assign s_tready = ctrl.in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign stat.in_valid = s_tvalid;
    assign stat.tick     = s_tdata[0];
    assign stat.is_sine  = (wave_sel_reg == WAVE_SINE);
    assign stat.out_free = !out_valid_reg || m_tready;

    mwop_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    mwop_wave #(.PHASE_BITS(PHASE_BITS)) u_wave
    (
        .phase       (phase_reg),
        .wave_select (wave_sel_reg),
        .lfsr        (lfsr_reg),
        .sample      (wave_sample),
        .lfsr_next   (lfsr_next)
    );

    mwop_mul u_mul
    (
        .clk     (clk),
        .en      (ctrl.mul_en),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= STEP_RST;
            wave_sel_reg   <= WAVE_SINE;
            amp_reg        <= GAIN_RST;
            pan_reg        <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PHASE_STEP:   phase_step_reg <= cfg_data;
                REG_WAVE_SELECT:  wave_sel_reg   <= cfg_data[WSEL_W-1:0];
                REG_AMPLITUDE:    amp_reg        <= cfg_data[GAIN_W-1:0];
                REG_PAN_POSITION: pan_reg        <= cfg_data[GAIN_W-1:0];
                default:          amp_reg        <= amp_reg;
            endcase
        end
    end

    assign step_ext = PHASE_BITS'(phase_step_reg);
    assign amp_sat  = (amp_reg > GAIN_ONE) ? GAIN_ONE : amp_reg;
    assign pan_sat  = (pan_reg > GAIN_ONE) ? GAIN_ONE : pan_reg;
    assign rpan     = GAIN_ONE - pan_sat;

    // quarter-wave index, mirrored in odd quadrants
    assign quad    = phase_reg[PHASE_BITS-1 -: 2];
    assign sin_idx = phase_reg[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign sin_mir = quad[0] ? (TBL_SIZE - {1'b0, sin_idx}) : {1'b0, sin_idx};
    assign sin_u   = U_W'(sin_mir) << (SIN_Q - SINE_TABLE_BITS);

    assign p_q30    = product[2*SIN_Q:SIN_Q];
    assign sa_now   = product[SA_W-1:0];
    assign sine_mag = clamp_sample($signed(CALC_W'(p_q30[U_W-1 -: SAMPLE_BITS])));
    assign sine_val = quad[1] ? -sine_mag : sine_mag;

    always_comb
    begin
        unique case (ctrl.mul_op)
            MOP_U_U:
            begin
                op_a = {2'b00, sin_u};
                op_b = {2'b00, sin_u};
            end
            MOP_C_U2:
            begin
                op_a = {2'b00, SIN_C};
                op_b = {2'b00, p_q30};
            end
            MOP_B_U2:
            begin
                op_a = {2'b00, U_W'(SIN_B - p_q30)};
                op_b = {2'b00, u2_reg};
            end
            MOP_A_U:
            begin
                op_a = {2'b00, U_W'(SIN_A - p_q30)};
                op_b = {2'b00, sin_u};
            end
            MOP_SAMPLE_AMP:
            begin
                op_a = MUL_W'(sample_reg);
                op_b = MUL_W'(amp_sat);
            end
            MOP_SA_PAN:
            begin
                op_a = MUL_W'(sa_now);
                op_b = MUL_W'(pan_sat);
            end
            MOP_SA_RPAN:
            begin
                op_a = MUL_W'(sa_reg);
                op_b = MUL_W'(rpan);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // phase and noise state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            lfsr_reg  <= LFSR_SEED;
        end
        else
        begin
            if (accept && s_tdata[0])
            begin
                phase_reg <= phase_reg + step_ext;
            end
            if (ctrl.load_wave && (wave_sel_reg == WAVE_NOISE))
            begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load_wave)
        begin
            sample_reg <= wave_sample;
        end
        else if (ctrl.load_sine)
        begin
            sample_reg <= sine_val;
        end
        if (ctrl.load_u2)
        begin
            u2_reg <= p_q30;
        end
        if (ctrl.load_sa)
        begin
            sa_reg <= sa_now;
        end
        if (ctrl.load_left)
        begin
            left_reg <= product[31:16];
        end
        if (ctrl.load_out)
        begin
            out_data_reg <= {product[31:16], left_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    `MWOP_ASSERT_NEXT(a_phase_step, clk, rst_n, accept && s_tdata[0], phase_reg == $past(phase_reg) + $past(step_ext), "phase did not advance by one step")
    `MWOP_ASSERT(a_busy_not_ready, clk, rst_n, ctrl.state != ST_IDLE, !s_tready, "ready while an item is in work")
    `MWOP_ASSERT(a_out_from_done, clk, rst_n, $rose(m_tvalid), $past(ctrl.state == ST_DONE), "result shown outside the final step")

endmodule

// ----- sim/multiwave_oscillator_pan_unit_tb.sv -----
// self-checking testbench for the multiwave oscillator with pan: predicts every stereo item
// from its own phase, lfsr and register copies and checks the output stream field by field
// depends on mwop_pkg and the multiwave_oscillator_pan_unit top level
module multiwave_oscillator_pan_unit_tb;

    import mwop_pkg::*;

    localparam int      SETTLE_CYCLES = 24;
    localparam int      QUIET_LIMIT   = 2000;
    localparam int      RANDOM_TICKS  = 1240;
    localparam int      MAX_REPORTS   = 10;
    localparam longint  FULL_SCALE    = 32768;
    localparam longint unsigned SINE_POLY_A = 64'd1686629713;
    localparam longint unsigned SINE_POLY_B = 64'd688904870;
    localparam longint unsigned SINE_POLY_C = 64'd76017005;
    localparam logic [WSEL_W-1:0] WAVE_UNUSED_LO = 3'd5;
    localparam logic [WSEL_W-1:0] WAVE_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [15:0] right;
        logic [15:0] left;
    } stereo_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [0] tick, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [15:0] left_sample, [31:16] right_sample
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [STEP_W-1:0] cfg_data = '0;

    // predictor state and register copies
    logic [31:0]       step_reg  = STEP_RST;
    logic [WSEL_W-1:0] wave_reg  = WAVE_SINE;
    logic [GAIN_W-1:0] amp_reg   = GAIN_RST;
    logic [GAIN_W-1:0] pan_reg   = GAIN_RST;
    logic [31:0]       phase_acc = 32'd0;
    logic [LFSR_W-1:0] lfsr      = LFSR_SEED;

    bit      pending_ticks[$];
    stereo_t predicted_samples[$];
    int      pending_items = 0;
    int      send_idle_pct = 22;
    int      recv_idle_pct = 76;
    int      error_count = 0;
    int      ticks_sent = 0;
    int      blanks_sent = 0;
    int      writes_done = 0;
    int      quiet_cycles = 0;

    multiwave_oscillator_pan_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic longint clamp_full(longint v);
        if (v > FULL_SCALE - 1)
        begin
            return FULL_SCALE - 1;
        end
        if (v < -FULL_SCALE)
        begin
            return -FULL_SCALE;
        end
        return v;
    endfunction

    // quarter-wave polynomial sine, table index mirrored in odd quadrants
    function automatic longint sine_value(logic [31:0] ph);
        logic [1:0]      quad;
        longint unsigned idx;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint          v;
        quad = ph[31:30];
        idx  = ph[29:20];
        if (quad[0])
        begin
            idx = 1024 - idx;
        end
        u  = idx << 20;
        u2 = (u * u) >> 30;
        t  = (SINE_POLY_C * u2) >> 30;
        t  = SINE_POLY_B - t;
        t  = (t * u2) >> 30;
        t  = SINE_POLY_A - t;
        v  = clamp_full(longint'(((t * u) >> 30) >> 15));
        return quad[1] ? -v : v;
    endfunction

    function automatic logic [15:0] apply_gain(longint smp, longint g, longint a);
        longint prod;
        prod = smp * g * a;
        return 16'(prod >>> 16);
    endfunction

    function automatic stereo_t synth_next_sample();
        longint  smp;
        longint  tri_pos;
        longint  amp;
        longint  pan;
        stereo_t res;
        phase_acc = phase_acc + step_reg;
        tri_pos   = longint'(phase_acc[31:15]);
        case (wave_reg)
            WAVE_SINE:     smp = sine_value(phase_acc);
            WAVE_SAWTOOTH: smp = clamp_full(FULL_SCALE - longint'(phase_acc[31:16]));
            WAVE_SQUARE:   smp = phase_acc[31] ? FULL_SCALE - 1 : -FULL_SCALE;
            WAVE_TRIANGLE: smp = clamp_full(phase_acc[31] ? tri_pos - 3 * FULL_SCALE
                                                          : FULL_SCALE - tri_pos);
            WAVE_NOISE:
            begin
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                smp  = longint'($signed(lfsr));
            end
            default:       smp = 0;
        endcase
        amp = (amp_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(amp_reg);
        pan = (pan_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(pan_reg);
        res.left  = apply_gain(smp, pan, amp);
        res.right = apply_gain(smp, 256 - pan, amp);
        return res;
    endfunction

    // sender side
    always @(posedge clk)
    begin : drive_items
        bit free_slot;
        if (rst_n)
        begin
            free_slot = !s_tvalid;
            if (s_tvalid && s_tready)
            begin
                free_slot = 1'b1;
                pending_items--;
                if (s_tdata[0])
                begin
                    predicted_samples.push_back(synth_next_sample());
                end
            end
            if (free_slot)
            begin
                if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tdata  <= {7'd0, pending_ticks.pop_front()};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver side and checking
    always @(posedge clk)
    begin : check_items
        stereo_t want;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready)
            begin
                if (predicted_samples.size() == 0)
                begin
                    flag_error($sformatf("unexpected output item %h", m_tdata));
                end
                else
                begin
                    want = predicted_samples.pop_front();
                    if (m_tdata[15:0] !== want.left)
                    begin
                        flag_error($sformatf("left_sample expected %0d got %0d",
                                             $signed(want.left), $signed(m_tdata[15:0])));
                    end
                    if (m_tdata[31:16] !== want.right)
                    begin
                        flag_error($sformatf("right_sample expected %0d got %0d",
                                             $signed(want.right), $signed(m_tdata[31:16])));
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [STEP_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_PHASE_STEP:   step_reg = data;
            REG_WAVE_SELECT:  wave_reg = data[WSEL_W-1:0];
            REG_AMPLITUDE:    amp_reg  = data[GAIN_W-1:0];
            REG_PAN_POSITION: pan_reg  = data[GAIN_W-1:0];
            default: ;
        endcase
        writes_done++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_item(bit tick);
        pending_ticks.push_back(tick);
        pending_items++;
        if (tick)
        begin
            ticks_sent++;
        end
        else
        begin
            blanks_sent++;
        end
    endtask

    // wait until every item is taken and every sample is out, then let the pipeline empty
    task automatic settle();
        while (pending_items != 0 || predicted_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one tick that lands the phase exactly on target
    task automatic tick_at_phase(logic [31:0] target);
        write_reg(REG_PHASE_STEP, target - phase_acc);
        queue_item(1'b1);
        settle();
    endtask

    function automatic logic [STEP_W-1:0] pick_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(0, 5))
            0:       g = 9'd0;
            1:       g = GAIN_ONE;
            2:       g = 9'h1FF;
            3:       g = 9'($urandom_range(257, 511));
            default: g = 9'($urandom_range(0, 256));
        endcase
        return {$urandom()} & ~32'h1FF | STEP_W'(g);
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3, 4, 5: return 32'($urandom_range(1, 1 << 24));
            default: return $urandom();
        endcase
    endfunction

    initial
    begin : stimulus
        int directed_ticks;
        int random_ticks;
        int burst;
        logic [WSEL_W-1:0] shape;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, a no-tick item in between
        queue_item(1'b0);
        queue_item(1'b1);
        queue_item(1'b1);
        queue_item(1'b0);
        queue_item(1'b1);
        settle();

        // sine on quadrant edges, full gain fully left
        write_reg(REG_AMPLITUDE, STEP_W'(GAIN_ONE));
        write_reg(REG_PAN_POSITION, STEP_W'(GAIN_ONE));
        tick_at_phase(32'd0);
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        repeat (4) queue_item(1'b1);
        settle();

        // sawtooth ends with amplitude saturated, fully right
        write_reg(REG_WAVE_SELECT, STEP_W'(WAVE_SAWTOOTH));
        write_reg(REG_AMPLITUDE, 32'h1FF);
        write_reg(REG_PAN_POSITION, 32'd0);
        tick_at_phase(32'd0);
        tick_at_phase(32'hFFFF_FFFF);

        // square on both sides of the half point
        write_reg(REG_WAVE_SELECT, STEP_W'(WAVE_SQUARE));
        tick_at_phase(32'h7FFF_FFFF);
        tick_at_phase(32'h8000_0000);

        // triangle corners, uneven pan
        write_reg(REG_WAVE_SELECT, STEP_W'(WAVE_TRIANGLE));
        write_reg(REG_PAN_POSITION, 32'd64);
        tick_at_phase(32'd0);
        tick_at_phase(32'h7FFF_FFFF);
        tick_at_phase(32'h8000_0000);
        tick_at_phase(32'hFFFF_FFFF);

        // noise with pan past one, then zero gain
        write_reg(REG_WAVE_SELECT, STEP_W'(WAVE_NOISE));
        write_reg(REG_AMPLITUDE, STEP_W'(GAIN_ONE));
        write_reg(REG_PAN_POSITION, 32'd300);
        write_reg(REG_PHASE_STEP, 32'd0);
        queue_item(1'b1);
        queue_item(1'b1);
        settle();
        write_reg(REG_AMPLITUDE, 32'd0);
        queue_item(1'b1);
        settle();

        // unused selectors give silence but still move the phase
        write_reg(REG_AMPLITUDE, STEP_W'(GAIN_ONE));
        write_reg(REG_PHASE_STEP, 32'h1234_5678);
        write_reg(REG_WAVE_SELECT, STEP_W'(WAVE_UNUSED_LO));
        queue_item(1'b1);
        settle();
        write_reg(REG_WAVE_SELECT, STEP_W'(WAVE_UNUSED_HI));
        queue_item(1'b1);
        settle();
        directed_ticks = ticks_sent;

        // random bursts, each under a fresh mix of settings
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS)
        begin
            if (random_ticks < RANDOM_TICKS / 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 76;
            end
            else if (random_ticks < 2 * RANDOM_TICKS / 3)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 9) < 6)
            begin
                write_reg(REG_PHASE_STEP, pick_step());
            end
            if ($urandom_range(0, 9) < 6)
            begin
                shape = ($urandom_range(0, 9) < 9) ? WSEL_W'($urandom_range(0, 4))
                                                   : WSEL_W'($urandom_range(5, 7));
                write_reg(REG_WAVE_SELECT, {$urandom()} & ~32'h7 | STEP_W'(shape));
            end
            if ($urandom_range(0, 9) < 6)
            begin
                write_reg(REG_AMPLITUDE, pick_gain());
            end
            if ($urandom_range(0, 9) < 6)
            begin
                write_reg(REG_PAN_POSITION, pick_gain());
            end
            burst = $urandom_range(8, 60);
            repeat (burst)
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    queue_item(1'b1);
                    random_ticks++;
                end
                else
                begin
                    queue_item(1'b0);
                end
            end
            settle();
        end

        if (predicted_samples.size() != 0)
        begin
            flag_error($sformatf("%0d samples never came out", predicted_samples.size()));
        end
        $display("covered %0d tick items (%0d directed) and %0d no-tick items, %0d writes",
                 ticks_sent, directed_ticks, blanks_sent, writes_done);
        $display("all shapes, unused selectors, gains past one, three pacing mixes");
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
